// ----- rtl/lrps_pkg.sv -----
// Shared constants and types for the line raster pixel stepper.
package lrps_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int ORIGIN_W           = 11;
    localparam int PIX_W              = 13;
    localparam int CFG_IDX_W          = 1;

    localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 11'd300;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

    // Per-word control bits handed from the setup stage to the stepper
    typedef struct packed {
        logic cmd;
        logic steep;
        logic x_neg;
        logic y_neg;
    } setup_flags_t;

endpackage

// ----- rtl/lrps_if.sv -----
// Channel interfaces: command request, pixel result and register write.
interface lrps_req_if #(
    parameter int COORD_BITS = lrps_pkg::COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lrps_pix_if;
    import lrps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last_pixel;
    logic                    pixel_valid;

    modport source (output valid, pixel_x, pixel_y, last_pixel, pixel_valid, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, pixel_valid, output ready);
endinterface

interface lrps_cfg_if;
    import lrps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ORIGIN_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/lrps_setup.sv -----
// Input stage: registers a command word with the line setup values derived from it.
module lrps_setup #(
    parameter int COORD_BITS = lrps_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lrps_req_if.sink                     req,
    input  logic                         advance,
    output logic                         s_valid,
    output lrps_pkg::setup_flags_t       s_flags,
    output logic [COORD_BITS-1:0]        s_start_x,
    output logic [COORD_BITS-1:0]        s_start_y,
    output logic [COORD_BITS-1:0]        s_major,
    output logic [COORD_BITS+2:0]        s_err_init,
    output logic [COORD_BITS+2:0]        s_inc_diag,
    output logic [COORD_BITS+2:0]        s_inc_straight
);
    import lrps_pkg::*;

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    logic           valid_reg;
    setup_flags_t   flags_reg, flags_next;
    logic [C-1:0]   start_x_reg, start_y_reg, major_reg, major_next;
    logic [E-1:0]   err_init_reg, err_init_next;
    logic [E-1:0]   inc_diag_reg, inc_diag_next, inc_straight_reg, inc_straight_next;

    logic [C:0]     dx, dy, adx_w, ady_w;
    logic [C-1:0]   adx, ady, minor;
    logic [E-1:0]   maj_e, min_e, min2;
    logic           take;

    assign take      = req.valid && req.ready;
    assign req.ready = !valid_reg || advance;

    always_comb
    begin
        dx    = {req.end_x[C-1], req.end_x} - {req.start_x[C-1], req.start_x};
        dy    = {req.end_y[C-1], req.end_y} - {req.start_y[C-1], req.start_y};
        adx_w = dx[C] ? (~dx + 1'b1) : dx;
        ady_w = dy[C] ? (~dy + 1'b1) : dy;
        adx   = adx_w[C-1:0];
        ady   = ady_w[C-1:0];

        flags_next.cmd   = req.cmd;
        flags_next.steep = ady > adx;
        flags_next.x_neg = dx[C];
        flags_next.y_neg = dy[C];

        // x is major on a tie
        major_next = flags_next.steep ? ady : adx;
        minor      = flags_next.steep ? adx : ady;

        maj_e = {{(E-C){1'b0}}, major_next};
        min_e = {{(E-C){1'b0}}, minor};
        min2  = {min_e[E-2:0], 1'b0};

        err_init_next     = min2 - maj_e;
        inc_diag_next     = min2 - {maj_e[E-2:0], 1'b0};
        inc_straight_next = min2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            flags_reg        <= flags_next;
            start_x_reg      <= req.start_x;
            start_y_reg      <= req.start_y;
            major_reg        <= major_next;
            err_init_reg     <= err_init_next;
            inc_diag_reg     <= inc_diag_next;
            inc_straight_reg <= inc_straight_next;
        end
    end

    assign s_valid        = valid_reg;
    assign s_flags        = flags_reg;
    assign s_start_x      = start_x_reg;
    assign s_start_y      = start_y_reg;
    assign s_major        = major_reg;
    assign s_err_init     = err_init_reg;
    assign s_inc_diag     = inc_diag_reg;
    assign s_inc_straight = inc_straight_reg;

endmodule

// ----- rtl/lrps_stepper.sv -----
// Stepper: line state, one midpoint step per step word, screen mapping and result register.
module lrps_stepper #(
    parameter int COORD_BITS = lrps_pkg::COORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_valid,
    input  lrps_pkg::setup_flags_t        s_flags,
    input  logic [COORD_BITS-1:0]         s_start_x,
    input  logic [COORD_BITS-1:0]         s_start_y,
    input  logic [COORD_BITS-1:0]         s_major,
    input  logic [COORD_BITS+2:0]         s_err_init,
    input  logic [COORD_BITS+2:0]         s_inc_diag,
    input  logic [COORD_BITS+2:0]         s_inc_straight,
    input  logic [lrps_pkg::ORIGIN_W-1:0] origin_x,
    input  logic [lrps_pkg::ORIGIN_W-1:0] origin_y,
    output logic                          advance,
    lrps_pix_if.source                    pix
);
    import lrps_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int E  = COORD_BITS + 3;
    localparam int SW = COORD_BITS + 12;

    // line state
    logic [C-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [E-1:0] err_reg, err_next, inc_diag_reg, inc_diag_next;
    logic [E-1:0] inc_straight_reg, inc_straight_next;
    logic [C-1:0] left_reg, left_next;
    logic         x_neg_reg, x_neg_next, y_neg_reg, y_neg_next;
    logic         steep_reg, steep_next, active_reg, active_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] pixel_x_reg, pixel_x_next, pixel_y_reg, pixel_y_next;
    logic             last_reg, last_next, pv_reg, pv_next;

    logic         diag, move_x, move_y;
    logic [C-1:0] step_x, step_y;
    logic [SW-1:0] sum_x, sum_y;

    assign advance = s_valid && (!out_valid_reg || pix.ready);

    always_comb
    begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        err_next          = err_reg;
        inc_diag_next     = inc_diag_reg;
        inc_straight_next = inc_straight_reg;
        left_next         = left_reg;
        x_neg_next        = x_neg_reg;
        y_neg_next        = y_neg_reg;
        steep_next        = steep_reg;
        active_next       = active_reg;
        last_next         = 1'b0;
        pv_next           = 1'b0;

        diag   = !err_reg[E-1];
        move_x = diag || !steep_reg;
        move_y = diag || steep_reg;
        step_x = x_neg_reg ? {C{1'b1}} : {{(C-1){1'b0}}, 1'b1};
        step_y = y_neg_reg ? {C{1'b1}} : {{(C-1){1'b0}}, 1'b1};

        if (s_flags.cmd == CMD_START)
        begin
            cur_x_next        = s_start_x;
            cur_y_next        = s_start_y;
            err_next          = s_err_init;
            inc_diag_next     = s_inc_diag;
            inc_straight_next = s_inc_straight;
            left_next         = s_major;
            x_neg_next        = s_flags.x_neg;
            y_neg_next        = s_flags.y_neg;
            steep_next        = s_flags.steep;
            active_next       = s_major != '0;
            last_next         = s_major == '0;
            pv_next           = 1'b1;
        end
        else if (active_reg)
        begin
            cur_x_next  = cur_x_reg + (move_x ? step_x : '0);
            cur_y_next  = cur_y_reg + (move_y ? step_y : '0);
            err_next    = err_reg + (diag ? inc_diag_reg : inc_straight_reg);
            left_next   = left_reg - 1'b1;
            active_next = left_reg != {{(C-1){1'b0}}, 1'b1};
            last_next   = !active_next;
            pv_next     = 1'b1;
        end

        // screen mapping; a step with no active line reports all zeros
        sum_x = {{(SW-ORIGIN_W){1'b0}}, origin_x} + {{(SW-C){cur_x_next[C-1]}}, cur_x_next};
        sum_y = {{(SW-ORIGIN_W){1'b0}}, origin_y} - {{(SW-C){cur_y_next[C-1]}}, cur_y_next};
        pixel_x_next = pv_next ? sum_x[PIX_W-1:0] : '0;
        pixel_y_next = pv_next ? sum_y[PIX_W-1:0] : '0;

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            err_reg          <= '0;
            inc_diag_reg     <= '0;
            inc_straight_reg <= '0;
            left_reg         <= '0;
            x_neg_reg        <= 1'b0;
            y_neg_reg        <= 1'b0;
            steep_reg        <= 1'b0;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                cur_x_reg        <= cur_x_next;
                cur_y_reg        <= cur_y_next;
                err_reg          <= err_next;
                inc_diag_reg     <= inc_diag_next;
                inc_straight_reg <= inc_straight_next;
                left_reg         <= left_next;
                x_neg_reg        <= x_neg_next;
                y_neg_reg        <= y_neg_next;
                steep_reg        <= steep_next;
                active_reg       <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_x_reg <= pixel_x_next;
            pixel_y_reg <= pixel_y_next;
            last_reg    <= last_next;
            pv_reg      <= pv_next;
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = pixel_x_reg;
    assign pix.pixel_y     = pixel_y_reg;
    assign pix.last_pixel  = last_reg;
    assign pix.pixel_valid = pv_reg;

endmodule

// ----- rtl/line_raster_pixel_stepper.sv -----
// Line raster pixel stepper: midpoint line rasterizer over all octants, with origin registers.
// A start word (cmd 0) loads two signed endpoints and returns the first pixel; each step
// word (cmd 1) returns the next pixel, with last_pixel set on the final endpoint and
// pixel_valid low when no line is active. The block takes one word per cycle when pix.ready
// does not hold it back, and returns one result word per word. The setup stage (endpoint
// deltas, axis choice, initial error) works on the word in the cycle it is accepted and
// registers it; the stepper, whose single add-and-compare error update closes the loop
// from one pixel to the next, then fills the result register, from which the pixel is
// taken. The result register lets a new word enter while a finished pixel waits to be
// taken. Origin registers are written through cfg and are always ready.
module line_raster_pixel_stepper #(
    parameter int COORD_BITS = lrps_pkg::COORD_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    lrps_req_if.sink   req,
    lrps_pix_if.source pix,
    lrps_cfg_if.sink   cfg
);
    import lrps_pkg::*;

    logic [ORIGIN_W-1:0]  origin_x_reg, origin_y_reg;
    logic                 s_valid, advance;
    setup_flags_t         s_flags;
    logic [COORD_BITS-1:0] s_start_x, s_start_y, s_major;
    logic [COORD_BITS+2:0] s_err_init, s_inc_diag, s_inc_straight;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= ORIGIN_RESET;
            origin_y_reg <= ORIGIN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_ORIGIN_X: origin_x_reg <= cfg.data;
                REG_ORIGIN_Y: origin_y_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    lrps_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .advance        (advance),
        .s_valid        (s_valid),
        .s_flags        (s_flags),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_major        (s_major),
        .s_err_init     (s_err_init),
        .s_inc_diag     (s_inc_diag),
        .s_inc_straight (s_inc_straight)
    );

    lrps_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_valid        (s_valid),
        .s_flags        (s_flags),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_major        (s_major),
        .s_err_init     (s_err_init),
        .s_inc_diag     (s_inc_diag),
        .s_inc_straight (s_inc_straight),
        .origin_x       (origin_x_reg),
        .origin_y       (origin_y_reg),
        .advance        (advance),
        .pix            (pix)
    );

endmodule
